>>> sv/rmq_pkg.sv
package rmq_pkg;

   localparam int FRACTION_BITS = 16;

   localparam int FW   = 18;
   localparam int VW   = 33;
   localparam int MW   = 31;
   localparam int SHW  = 5;
   localparam int SQW  = 2 * MW;
   localparam int SUMW = 64;
   localparam int NW   = 32;
   localparam int QB   = FRACTION_BITS + 1;
   localparam int DW   = FRACTION_BITS + NW + 1;
   localparam int SW   = QB + FW;

   typedef logic signed [FW-1:0] field_type;
   typedef logic signed [VW-1:0] vec_type;
   typedef logic [MW-1:0]        mag_type;
   typedef logic [QB-1:0]        quo_type;

   typedef struct packed {
      mag_type [3:0] mag;
      logic [3:0]    neg;
      logic          deg;
   } side_type;

   localparam field_type OUT_MAX = 18'sd131071;
   localparam field_type OUT_MIN = -18'sd131072;
   localparam vec_type   ONE_V   = VW'(1) <<< FRACTION_BITS;
   localparam field_type IDENT_W = (FRACTION_BITS >= FW - 1) ? OUT_MAX
                                                             : FW'(1 << FRACTION_BITS);

endpackage

>>> sv/rmq_if.sv
interface rmq_req_if;
   logic                 valid;
   logic                 ready;
   rmq_pkg::field_type   r00, r01, r02, r10, r11, r12, r20, r21, r22;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   output ready);
endinterface

interface rmq_rsp_if;
   logic                 valid;
   logic                 ready;
   rmq_pkg::field_type   qw, qx, qy, qz;
   logic                 degenerate;

   modport source (output valid, qw, qx, qy, qz, degenerate, input ready);
   modport sink   (input valid, qw, qx, qy, qz, degenerate, output ready);
endinterface

>>> sv/rmq_sqrt.sv
module rmq_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [rmq_pkg::SUMW-1:0]  in_sum,
   input  rmq_pkg::side_type         in_side,
   output logic                      out_valid,
   output logic [rmq_pkg::NW-1:0]    out_norm,
   output rmq_pkg::side_type         out_side
);

   localparam int NW   = rmq_pkg::NW;
   localparam int SUMW = rmq_pkg::SUMW;
   localparam int RW   = NW + 1;
   localparam int CW   = NW + 3;

   logic [RW-1:0]     rem_ff   [NW];
   logic [RW-1:0]     rem_in   [NW];
   logic [NW-1:0]     root_ff  [NW];
   logic [NW-1:0]     root_in  [NW];
   logic [SUMW-1:0]   rad_ff   [NW];
   logic              valid_ff [NW];
   rmq_pkg::side_type side_ff  [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [RW-1:0]     p_rem;
      logic [NW-1:0]     p_root;
      logic [SUMW-1:0]   p_rad;
      logic              p_valid;
      rmq_pkg::side_type p_side;
      logic [CW-1:0]     cur;
      logic [CW-1:0]     trial;

      if (k == 0) begin : g_first
         assign p_rem   = '0;
         assign p_root  = '0;
         assign p_rad   = in_sum;
         assign p_valid = in_valid;
         assign p_side  = in_side;
      end else begin : g_next
         assign p_rem   = rem_ff[k-1];
         assign p_root  = root_ff[k-1];
         assign p_rad   = rad_ff[k-1];
         assign p_valid = valid_ff[k-1];
         assign p_side  = side_ff[k-1];
      end

      assign cur   = {p_rem, p_rad[SUMW-1 -: 2]};
      assign trial = CW'({p_root, 2'b01});

      always_comb begin
         if (cur >= trial) begin
            rem_in[k]  = RW'(cur - trial);
            root_in[k] = {p_root[NW-2:0], 1'b1};
         end else begin
            rem_in[k]  = RW'(cur);
            root_in[k] = {p_root[NW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= p_valid;
         end
         if (advance) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= p_rad << 2;
            side_ff[k] <= p_side;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_norm  = root_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

>>> sv/rmq_div.sv
module rmq_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [rmq_pkg::NW-1:0]    in_norm,
   input  rmq_pkg::side_type         in_side,
   output logic                      out_valid,
   output rmq_pkg::quo_type          out_quo [4],
   output rmq_pkg::side_type         out_side
);

   localparam int NW = rmq_pkg::NW;
   localparam int DW = rmq_pkg::DW;
   localparam int QB = rmq_pkg::QB;
   localparam int F  = rmq_pkg::FRACTION_BITS;

   logic [DW-1:0]     rem_ff   [QB][4];
   logic [DW-1:0]     rem_in   [QB][4];
   rmq_pkg::quo_type  quo_ff   [QB][4];
   rmq_pkg::quo_type  quo_in   [QB][4];
   logic [NW-1:0]     norm_ff  [QB];
   logic              valid_ff [QB];
   rmq_pkg::side_type side_ff  [QB];

   for (genvar t = 0; t < QB; t++) begin : g_stage
      localparam int J = QB - 1 - t;
      logic [DW-1:0]     p_rem [4];
      rmq_pkg::quo_type  p_quo [4];
      logic [NW-1:0]     p_norm;
      logic              p_valid;
      rmq_pkg::side_type p_side;
      logic [DW-1:0]     dvs;

      if (t == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < 4; i++) begin
               p_rem[i] = (DW'(in_side.mag[i]) << F) + DW'(in_norm >> 1);
               p_quo[i] = '0;
            end
         end
         assign p_norm  = in_norm;
         assign p_valid = in_valid;
         assign p_side  = in_side;
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < 4; i++) begin
               p_rem[i] = rem_ff[t-1][i];
               p_quo[i] = quo_ff[t-1][i];
            end
         end
         assign p_norm  = norm_ff[t-1];
         assign p_valid = valid_ff[t-1];
         assign p_side  = side_ff[t-1];
      end

      assign dvs = DW'(p_norm) << J;

      always_comb begin
         for (int i = 0; i < 4; i++) begin
            quo_in[t][i] = p_quo[i];
            if (p_rem[i] >= dvs) begin
               rem_in[t][i]    = p_rem[i] - dvs;
               quo_in[t][i][J] = 1'b1;
            end else begin
               rem_in[t][i]    = p_rem[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[t] <= 1'b0;
         end else if (advance) begin
            valid_ff[t] <= p_valid;
         end
         if (advance) begin
            for (int i = 0; i < 4; i++) begin
               rem_ff[t][i] <= rem_in[t][i];
               quo_ff[t][i] <= quo_in[t][i];
            end
            norm_ff[t] <= p_norm;
            side_ff[t] <= p_side;
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_side  = side_ff[QB-1];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         out_quo[i] = quo_ff[QB-1][i];
      end
   end

endmodule

>>> sv/rotation_matrix_to_quaternion_core.sv
// Channel   Direction  Handshake       Payload
// req_port  in         valid / ready   r00 r01 r02 r10 r11 r12 r20 r21 r22
// rsp_port  out        valid / ready   qw qx qy qz degenerate
//
// A request may enter every cycle that the pipeline advances; each passes the front stages,
// the one-bit-per-stage square root, the one-bit-per-stage dividers and the output register.
// Reset clears every valid bit; the payload registers are not reset.
// The whole pipeline advances whenever the output register is empty or being taken.
module rotation_matrix_to_quaternion_core (
   input  logic      clock,
   input  logic      reset,
   rmq_req_if.sink   req_port,
   rmq_rsp_if.source rsp_port
);

   localparam int VW  = rmq_pkg::VW;
   localparam int MW  = rmq_pkg::MW;
   localparam int SHW = rmq_pkg::SHW;
   localparam int SQW = rmq_pkg::SQW;
   localparam int SW  = rmq_pkg::SW;

   logic advance;

   logic                 rsp_valid_ff;
   rmq_pkg::field_type   rsp_q_ff [4];
   rmq_pkg::field_type   rsp_q_in [4];
   logic                 rsp_deg_ff;

   assign advance        = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = advance;

   rmq_pkg::vec_type e [9];
   rmq_pkg::vec_type tr;
   rmq_pkg::vec_type rad;
   rmq_pkg::vec_type va [4];
   logic [1:0]       big;

   always_comb begin
      e[0] = VW'(req_port.r00);
      e[1] = VW'(req_port.r01);
      e[2] = VW'(req_port.r02);
      e[3] = VW'(req_port.r10);
      e[4] = VW'(req_port.r11);
      e[5] = VW'(req_port.r12);
      e[6] = VW'(req_port.r20);
      e[7] = VW'(req_port.r21);
      e[8] = VW'(req_port.r22);
      tr = e[0] + e[4] + e[8];
      for (int i = 0; i < 4; i++) begin
         va[i] = '0;
      end
      if (tr > 0) begin
         big   = 2'd0;
         rad   = rmq_pkg::ONE_V + tr;
         va[1] = e[7] - e[5];
         va[2] = e[2] - e[6];
         va[3] = e[3] - e[1];
      end else if (e[0] > e[4] && e[0] > e[8]) begin
         big   = 2'd1;
         rad   = rmq_pkg::ONE_V + e[0] - e[4] - e[8];
         va[0] = e[7] - e[5];
         va[2] = e[1] + e[3];
         va[3] = e[2] + e[6];
      end else if (e[4] > e[8]) begin
         big   = 2'd2;
         rad   = rmq_pkg::ONE_V + e[4] - e[0] - e[8];
         va[0] = e[2] - e[6];
         va[1] = e[1] + e[3];
         va[3] = e[5] + e[7];
      end else begin
         big   = 2'd3;
         rad   = rmq_pkg::ONE_V + e[8] - e[0] - e[4];
         va[0] = e[3] - e[1];
         va[1] = e[2] + e[6];
         va[2] = e[5] + e[7];
      end
      if (rad < 0) begin
         rad = '0;
      end
      va[big] = rad;
   end

   logic             s1_valid_ff;
   rmq_pkg::vec_type s1_v_ff [4];
   logic             s1_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_port.valid;
      end
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            s1_v_ff[i] <= va[i];
         end
         s1_deg_ff <= (rad == '0);
      end
   end

   rmq_pkg::side_type s2_side_in;
   rmq_pkg::mag_type  m01, m23, s2_max_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s2_side_in.neg[i] = s1_v_ff[i] < 0;
         s2_side_in.mag[i] = (s1_v_ff[i] < 0) ? MW'(-s1_v_ff[i]) : MW'(s1_v_ff[i]);
      end
      s2_side_in.deg = s1_deg_ff;
      m01       = (s2_side_in.mag[0] > s2_side_in.mag[1]) ? s2_side_in.mag[0]
                                                          : s2_side_in.mag[1];
      m23       = (s2_side_in.mag[2] > s2_side_in.mag[3]) ? s2_side_in.mag[2]
                                                          : s2_side_in.mag[3];
      s2_max_in = (m01 > m23) ? m01 : m23;
   end

   logic              s2_valid_ff;
   rmq_pkg::side_type s2_side_ff;
   rmq_pkg::mag_type  s2_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_side_ff <= s2_side_in;
         s2_max_ff  <= s2_max_in;
      end
   end

   logic [SHW-1:0] s3_sh_in;

   always_comb begin
      s3_sh_in = '0;
      for (int i = 0; i < MW; i++) begin
         if (s2_max_ff[i]) begin
            s3_sh_in = SHW'(MW - 1 - i);
         end
      end
   end

   logic              s3_valid_ff;
   rmq_pkg::side_type s3_side_ff;
   logic [SHW-1:0]    s3_sh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_side_ff <= s2_side_ff;
         s3_sh_ff   <= s3_sh_in;
      end
   end

   rmq_pkg::side_type s4_side_in;

   always_comb begin
      s4_side_in = s3_side_ff;
      for (int i = 0; i < 4; i++) begin
         s4_side_in.mag[i] = s3_side_ff.mag[i] << s3_sh_ff;
      end
   end

   logic              s4_valid_ff;
   rmq_pkg::side_type s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_side_ff <= s4_side_in;
      end
   end

   logic              s5_valid_ff;
   rmq_pkg::side_type s5_side_ff;
   logic [SQW-1:0]    s5_sq_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s5_side_ff <= s4_side_ff;
         for (int i = 0; i < 4; i++) begin
            s5_sq_ff[i] <= SQW'(s4_side_ff.mag[i]) * SQW'(s4_side_ff.mag[i]);
         end
      end
   end

   logic                     s6_valid_ff;
   rmq_pkg::side_type        s6_side_ff;
   logic [rmq_pkg::SUMW-1:0] s6_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (advance) begin
         s6_side_ff <= s5_side_ff;
         s6_sum_ff  <= rmq_pkg::SUMW'(s5_sq_ff[0]) + rmq_pkg::SUMW'(s5_sq_ff[1])
                     + rmq_pkg::SUMW'(s5_sq_ff[2]) + rmq_pkg::SUMW'(s5_sq_ff[3]);
      end
   end

   logic                   sq_valid;
   logic [rmq_pkg::NW-1:0] sq_norm;
   rmq_pkg::side_type      sq_side;

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s6_valid_ff),
      .in_sum    (s6_sum_ff),
      .in_side   (s6_side_ff),
      .out_valid (sq_valid),
      .out_norm  (sq_norm),
      .out_side  (sq_side)
   );

   logic              dv_valid;
   rmq_pkg::quo_type  dv_quo [4];
   rmq_pkg::side_type dv_side;

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid),
      .in_norm   (sq_norm),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (dv_side.neg[i]) begin
            rsp_q_in[i] = (SW'(dv_quo[i]) > SW'(131072)) ? rmq_pkg::OUT_MIN
                                                          : -rmq_pkg::FW'(dv_quo[i]);
         end else begin
            rsp_q_in[i] = (SW'(dv_quo[i]) > SW'(131071)) ? rmq_pkg::OUT_MAX
                                                          : rmq_pkg::FW'(dv_quo[i]);
         end
      end
      if (dv_side.deg) begin
         rsp_q_in[0] = rmq_pkg::IDENT_W;
         rsp_q_in[1] = '0;
         rsp_q_in[2] = '0;
         rsp_q_in[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            rsp_q_ff[i] <= rsp_q_in[i];
         end
         rsp_deg_ff <= dv_side.deg;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.qw         = rsp_q_ff[0];
   assign rsp_port.qx         = rsp_q_ff[1];
   assign rsp_port.qy         = rsp_q_ff[2];
   assign rsp_port.qz         = rsp_q_ff[3];
   assign rsp_port.degenerate = rsp_deg_ff;

endmodule
